// ===== sv/weighted_mean_outlier_clip_macros.svh =====
// assertion macros for the weighted mean outlier clip block
// taken in by the modules that check their own logic; no other dependencies
`ifndef WEIGHTED_MEAN_OUTLIER_CLIP_MACROS_SVH
`define WEIGHTED_MEAN_OUTLIER_CLIP_MACROS_SVH
`ifndef NO_ASSERTIONS
// antecedent implies consequent in the same cycle
`define WMOC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// antecedent implies consequent in the next cycle
`define WMOC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define WMOC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define WMOC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== sv/wmoc_pkg.sv =====
// shared types and constants of the weighted mean outlier clip block
// no dependencies; used by every module of the block
package wmoc_pkg;

    // field widths
    localparam int MAG_W       = 24;
    localparam int WT_W        = 24;
    localparam int CLIPW_W     = 24;
    localparam int SIGMA_W     = 16;
    localparam int MEAN_W      = 24;
    localparam int INDEX_OUT_W = 6;
    localparam int COUNT_OUT_W = 7;

    // stream widths
    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 40;
    localparam int OUT_TUSER_W = 2;

    // clip threshold after reset, 3.0 in Q8.8
    localparam logic [SIGMA_W-1:0] SIGMA_RESET = 16'd768;

    // deviation arithmetic
    localparam int PROD_W    = MAG_W + WT_W;
    localparam int DIFF_W    = MAG_W + 1;
    localparam int AD_W      = MAG_W;
    localparam int SQ_W      = 2 * AD_W;
    localparam int SQ_LO_W   = SQ_W / 2;
    localparam int PART_W    = SQ_LO_W + CLIPW_W;
    localparam int FULL_W    = SQ_W + CLIPW_W + 1;
    localparam int DEV_W     = 64;
    localparam int THR_SHIFT = 20;

    // descriptor queue depth, also the number of store banks
    localparam int QUEUE_DEPTH = 2;

    // one stored detection
    typedef struct packed {
        logic                        fit;
        logic [CLIPW_W-1:0]          clipw;
        logic signed [MAG_W-1:0]     mag;
    } store_word_t;

    // descriptor queue status
    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    // back end sequencer
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_SCAN,
        BK_FINISH
    } back_state_t;

endpackage

// ===== sv/wmoc_front.sv =====
// front end: accepts detection beats, writes the store, keeps group sums
// depends on wmoc_pkg; hands one descriptor per group to the queue
module wmoc_front #(
    parameter int MAX_DETECTIONS = 64,
    localparam int CNT_W  = $clog2(MAX_DETECTIONS + 1),
    localparam int IDX_W  = $clog2(MAX_DETECTIONS),
    localparam int SUMW_W = wmoc_pkg::WT_W + CNT_W,
    localparam int SUMM_W = wmoc_pkg::PROD_W + CNT_W,
    localparam int DESC_W = 2 + 2 * CNT_W + SUMW_W + SUMM_W
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [wmoc_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    input  logic                              s_axis_tuser,
    input  logic                              s_axis_tlast,
    input  wmoc_pkg::queue_status_t           q_status,
    output logic                              q_push,
    output logic [DESC_W-1:0]                 q_push_data,
    output logic                              st_wr_en,
    output logic [IDX_W:0]                    st_wr_addr,
    output wmoc_pkg::store_word_t             st_wr_data
);

    typedef struct packed {
        logic                       bank;
        logic [CNT_W-1:0]           n_items;
        logic [CNT_W-1:0]           fit_cnt;
        logic                       overflow;
        logic [SUMW_W-1:0]          sum_w;
        logic signed [SUMM_W-1:0]   sum_m;
    } desc_t;

    logic                                   accept;
    logic                                   in_room;
    logic                                   in_fit;
    logic signed [wmoc_pkg::MAG_W-1:0]      in_mag;
    logic [wmoc_pkg::WT_W-1:0]              in_wt;
    logic [wmoc_pkg::CLIPW_W-1:0]           in_cw;

    logic [CNT_W-1:0]                       item_cnt_reg;
    logic [CNT_W-1:0]                       fit_cnt_reg;
    logic                                   overflow_reg;
    logic                                   bank_reg;
    logic                                   push_pend_reg;
    logic signed [wmoc_pkg::PROD_W-1:0]     prod_reg;
    logic [wmoc_pkg::WT_W-1:0]              wt_add_reg;
    logic signed [SUMM_W-1:0]               sum_m_reg;
    logic signed [SUMM_W-1:0]               sum_m_next;
    logic [SUMW_W-1:0]                      sum_w_reg;
    logic [SUMW_W-1:0]                      sum_w_next;
    desc_t                                  desc;

    // unpack the beat
    assign in_mag  = $signed(s_axis_tdata[wmoc_pkg::MAG_W-1:0]);
    assign in_wt   = s_axis_tdata[wmoc_pkg::MAG_W +: wmoc_pkg::WT_W];
    assign in_cw   = s_axis_tdata[wmoc_pkg::MAG_W + wmoc_pkg::WT_W +: wmoc_pkg::CLIPW_W];
    assign in_fit  = !s_axis_tuser && (in_wt != '0);
    assign in_room = item_cnt_reg < CNT_W'(MAX_DETECTIONS);

    // no beat in the cycle that closes a group, none while both banks are taken
    assign s_axis_tready = !push_pend_reg && !q_status.full;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // store write port
    assign st_wr_en         = accept && in_room;
    assign st_wr_addr       = {bank_reg, item_cnt_reg[IDX_W-1:0]};
    assign st_wr_data.fit   = in_fit;
    assign st_wr_data.clipw = in_cw;
    assign st_wr_data.mag   = in_mag;

    // counters and overflow
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_cnt_reg <= '0;
            fit_cnt_reg  <= '0;
            overflow_reg <= 1'b0;
            bank_reg     <= 1'b0;
        end
        else if (push_pend_reg)
        begin
            item_cnt_reg <= '0;
            fit_cnt_reg  <= '0;
            overflow_reg <= 1'b0;
            bank_reg     <= !bank_reg;
        end
        else if (accept)
        begin
            if (in_room)
            begin
                item_cnt_reg <= item_cnt_reg + CNT_W'(1);
                if (in_fit)
                begin
                    fit_cnt_reg <= fit_cnt_reg + CNT_W'(1);
                end
            end
            else
            begin
                overflow_reg <= 1'b1;
            end
        end
    end

    // weighted magnitude product, registered ahead of the accumulators
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_reg      <= '0;
            wt_add_reg    <= '0;
            push_pend_reg <= 1'b0;
        end
        else
        begin
            push_pend_reg <= accept && s_axis_tlast;
            if (accept && in_room && !s_axis_tuser)
            begin
                prod_reg   <= in_mag * $signed({1'b0, in_wt});
                wt_add_reg <= in_wt;
            end
            else
            begin
                prod_reg   <= '0;
                wt_add_reg <= '0;
            end
        end
    end

    // running sums
    assign sum_m_next = sum_m_reg + SUMM_W'(prod_reg);
    assign sum_w_next = sum_w_reg + SUMW_W'(wt_add_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_m_reg <= '0;
            sum_w_reg <= '0;
        end
        else if (push_pend_reg)
        begin
            sum_m_reg <= '0;
            sum_w_reg <= '0;
        end
        else
        begin
            sum_m_reg <= sum_m_next;
            sum_w_reg <= sum_w_next;
        end
    end

    // group descriptor, pushed the cycle after the last beat
    assign desc.bank     = bank_reg;
    assign desc.n_items  = item_cnt_reg;
    assign desc.fit_cnt  = fit_cnt_reg;
    assign desc.overflow = overflow_reg;
    assign desc.sum_w    = sum_w_next;
    assign desc.sum_m    = sum_m_next;

    assign q_push      = push_pend_reg;
    assign q_push_data = desc;

endmodule

// ===== sv/wmoc_queue.sv =====
// two-entry descriptor queue between the front and back ends
// depends on wmoc_pkg and the assertion macro header
`include "weighted_mean_outlier_clip_macros.svh"
module wmoc_queue #(
    parameter int WIDTH = 8
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    input  logic [WIDTH-1:0]          push_data,
    input  logic                      pop,
    output logic [WIDTH-1:0]          head_data,
    output wmoc_pkg::queue_status_t   status
);

    localparam int PTR_W = $clog2(wmoc_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(wmoc_pkg::QUEUE_DEPTH + 1);

    logic [WIDTH-1:0]   slot_reg [wmoc_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    assign head_data    = slot_reg[rd_ptr_reg];
    assign status.full  = count_reg == CNT_W'(wmoc_pkg::QUEUE_DEPTH);
    assign status.empty = count_reg == '0;

    // a full queue takes no descriptor, an empty one gives none
    `WMOC_ASSERT_IMPL(a_no_push_full, clk, rst_n, push, !status.full, "push into full queue")
    `WMOC_ASSERT_IMPL(a_no_pop_empty, clk, rst_n, pop, !status.empty, "pop from empty queue")

endmodule

// ===== sv/wmoc_div.sv =====
// iterative signed by unsigned divider for the weighted mean, one bit a cycle
// depends on wmoc_pkg; quotient truncates toward zero and must fit MEAN_W bits
module wmoc_div #(
    parameter int NUM_W = 55,
    parameter int DEN_W = 31
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [NUM_W-1:0]             num,
    input  logic [DEN_W-1:0]                    den,
    output logic                                done,
    output logic signed [wmoc_pkg::MEAN_W-1:0]  quot
);

    localparam int Q_W    = wmoc_pkg::MEAN_W;
    localparam int STEP_W = $clog2(Q_W);

    logic [NUM_W-1:0]   num_mag;
    logic [NUM_W-1:0]   rem_reg;
    logic [NUM_W-1:0]   den_sh_reg;
    logic [Q_W-1:0]     q_reg;
    logic [STEP_W-1:0]  step_reg;
    logic               neg_reg;
    logic               busy_reg;
    logic               done_reg;
    logic               fits;

    assign num_mag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
    assign fits    = rem_reg >= den_sh_reg;

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= STEP_W'(Q_W - 1);
        end
        else if (busy_reg)
        begin
            if (step_reg == '0)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
            else
            begin
                step_reg <= step_reg - STEP_W'(1);
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // restoring division on magnitudes, quotient bits from the top
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg    <= num_mag;
            den_sh_reg <= NUM_W'(den) << (Q_W - 1);
            q_reg      <= '0;
            neg_reg    <= num[NUM_W-1];
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_reg <= rem_reg - den_sh_reg;
            end
            q_reg      <= {q_reg[Q_W-2:0], fits};
            den_sh_reg <= den_sh_reg >> 1;
        end
    end

    assign done = done_reg;
    assign quot = neg_reg ? -$signed(q_reg) : $signed(q_reg);

endmodule

// ===== sv/wmoc_back.sv =====
// back end: detection store, mean division, outlier scan pipeline, result beat
// depends on wmoc_pkg, wmoc_div and the assertion macro header
`include "weighted_mean_outlier_clip_macros.svh"
module wmoc_back #(
    parameter int MAX_DETECTIONS = 64,
    localparam int CNT_W  = $clog2(MAX_DETECTIONS + 1),
    localparam int IDX_W  = $clog2(MAX_DETECTIONS),
    localparam int SUMW_W = wmoc_pkg::WT_W + CNT_W,
    localparam int SUMM_W = wmoc_pkg::PROD_W + CNT_W,
    localparam int DESC_W = 2 + 2 * CNT_W + SUMW_W + SUMM_W
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               st_wr_en,
    input  logic [IDX_W:0]                     st_wr_addr,
    input  wmoc_pkg::store_word_t              st_wr_data,
    input  logic [DESC_W-1:0]                  head_data,
    input  wmoc_pkg::queue_status_t            q_status,
    output logic                               q_pop,
    input  logic [wmoc_pkg::SIGMA_W-1:0]       clip_sigma,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [wmoc_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    output logic [wmoc_pkg::OUT_TUSER_W-1:0]   m_axis_tuser
);

    typedef struct packed {
        logic                       bank;
        logic [CNT_W-1:0]           n_items;
        logic [CNT_W-1:0]           fit_cnt;
        logic                       overflow;
        logic [SUMW_W-1:0]          sum_w;
        logic signed [SUMM_W-1:0]   sum_m;
    } desc_t;

    // two banks of detections, one per queue slot
    localparam int STORE_DEPTH = 2 ** (IDX_W + 1);

    desc_t                                      head;
    wmoc_pkg::back_state_t                      state_reg;
    wmoc_pkg::back_state_t                      state_next;

    logic                                       group_ok;
    logic                                       out_free;
    logic                                       div_start;
    logic                                       scan_run;
    logic                                       finish;
    logic                                       div_done;
    logic signed [wmoc_pkg::MEAN_W-1:0]         div_quot;
    logic signed [wmoc_pkg::MEAN_W-1:0]         mean_reg;
    logic [2*wmoc_pkg::SIGMA_W-1:0]             clip_sq_reg;
    logic [wmoc_pkg::DEV_W-1:0]                 thr;

    wmoc_pkg::store_word_t                      store_mem [STORE_DEPTH];
    wmoc_pkg::store_word_t                      rd_word_reg;
    logic [IDX_W:0]                             rd_addr;
    logic [CNT_W-1:0]                           iss_cnt_reg;
    logic                                       issue;
    logic                                       scan_done;

    logic                                       v1_reg;
    logic                                       v2_reg;
    logic                                       v3_reg;
    logic                                       v4_reg;
    logic                                       v5_reg;
    logic [IDX_W-1:0]                           idx1_reg;
    logic [IDX_W-1:0]                           idx2_reg;
    logic [IDX_W-1:0]                           idx3_reg;
    logic [IDX_W-1:0]                           idx4_reg;
    logic [IDX_W-1:0]                           idx5_reg;
    logic signed [wmoc_pkg::DIFF_W-1:0]         diff;
    logic [wmoc_pkg::DIFF_W-1:0]                diff_abs;
    logic [wmoc_pkg::AD_W-1:0]                  ad2_reg;
    logic [wmoc_pkg::CLIPW_W-1:0]               cw2_reg;
    logic [wmoc_pkg::SQ_W-1:0]                  sq3_reg;
    logic [wmoc_pkg::CLIPW_W-1:0]               cw3_reg;
    logic [wmoc_pkg::PART_W-1:0]                plo4_reg;
    logic [wmoc_pkg::PART_W-1:0]                phi4_reg;
    logic [wmoc_pkg::FULL_W-1:0]                dev_full;
    logic [wmoc_pkg::DEV_W-1:0]                 dev5_reg;
    logic [wmoc_pkg::DEV_W-1:0]                 max_reg;
    logic [IDX_W-1:0]                           worst_reg;
    logic                                       found_reg;

    logic                                       res_clipped;
    logic [wmoc_pkg::INDEX_OUT_W-1:0]           res_worst;
    logic [wmoc_pkg::COUNT_OUT_W-1:0]           res_count;
    logic signed [wmoc_pkg::MEAN_W-1:0]         res_mean;
    logic                                       m_valid_reg;
    logic [wmoc_pkg::OUT_TDATA_W-1:0]           m_tdata_reg;
    logic [wmoc_pkg::OUT_TUSER_W-1:0]           m_tuser_reg;

    assign head     = head_data;
    assign group_ok = (head.fit_cnt >= CNT_W'(2)) && (head.sum_w != '0);
    assign out_free = !m_valid_reg || m_axis_tready;

    // sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= wmoc_pkg::BK_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            wmoc_pkg::BK_IDLE:
            begin
                if (!q_status.empty)
                begin
                    state_next = group_ok ? wmoc_pkg::BK_DIV : wmoc_pkg::BK_FINISH;
                end
            end
            wmoc_pkg::BK_DIV:
            begin
                if (div_done)
                begin
                    state_next = wmoc_pkg::BK_SCAN;
                end
            end
            wmoc_pkg::BK_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = wmoc_pkg::BK_FINISH;
                end
            end
            wmoc_pkg::BK_FINISH:
            begin
                if (out_free)
                begin
                    state_next = wmoc_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = wmoc_pkg::BK_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        div_start = 1'b0;
        scan_run  = 1'b0;
        finish    = 1'b0;
        case (state_reg)
            wmoc_pkg::BK_IDLE:
            begin
                div_start = !q_status.empty && group_ok;
            end
            wmoc_pkg::BK_SCAN:
            begin
                scan_run = 1'b1;
            end
            wmoc_pkg::BK_FINISH:
            begin
                finish = out_free;
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    assign q_pop = finish;

    // weighted mean
    wmoc_div #(
        .NUM_W (SUMM_W),
        .DEN_W (SUMW_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (head.sum_m),
        .den   (head.sum_w),
        .done  (div_done),
        .quot  (div_quot)
    );

    always_ff @(posedge clk)
    begin
        if (div_done)
        begin
            mean_reg <= div_quot;
        end
        clip_sq_reg <= clip_sigma * clip_sigma;
    end

    assign thr = wmoc_pkg::DEV_W'(clip_sq_reg) << wmoc_pkg::THR_SHIFT;

    // detection store, one write and one registered read port
    assign rd_addr = {head.bank, iss_cnt_reg[IDX_W-1:0]};

    always_ff @(posedge clk)
    begin
        if (st_wr_en)
        begin
            store_mem[st_wr_addr] <= st_wr_data;
        end
        rd_word_reg <= store_mem[rd_addr];
    end

    // read issue over the stored detections
    assign issue     = scan_run && (iss_cnt_reg < head.n_items);
    assign scan_done = scan_run && !issue &&
                       !(v1_reg || v2_reg || v3_reg || v4_reg || v5_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iss_cnt_reg <= '0;
        end
        else if (div_start)
        begin
            iss_cnt_reg <= '0;
        end
        else if (issue)
        begin
            iss_cnt_reg <= iss_cnt_reg + CNT_W'(1);
        end
    end

    // scan pipeline valids, entries that are not fittable drop out here
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= issue;
            v2_reg <= v1_reg && rd_word_reg.fit;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    // deviation from the mean
    assign diff     = wmoc_pkg::DIFF_W'(rd_word_reg.mag) - wmoc_pkg::DIFF_W'(mean_reg);
    assign diff_abs = diff[wmoc_pkg::DIFF_W-1] ? wmoc_pkg::DIFF_W'(-diff)
                                               : wmoc_pkg::DIFF_W'(diff);

    // square, then two partial products with the clip weight
    assign dev_full = wmoc_pkg::FULL_W'(plo4_reg)
                    + (wmoc_pkg::FULL_W'(phi4_reg) << wmoc_pkg::SQ_LO_W);

    always_ff @(posedge clk)
    begin
        idx1_reg <= iss_cnt_reg[IDX_W-1:0];
        idx2_reg <= idx1_reg;
        ad2_reg  <= diff_abs[wmoc_pkg::AD_W-1:0];
        cw2_reg  <= rd_word_reg.clipw;
        idx3_reg <= idx2_reg;
        sq3_reg  <= wmoc_pkg::SQ_W'(ad2_reg) * wmoc_pkg::SQ_W'(ad2_reg);
        cw3_reg  <= cw2_reg;
        idx4_reg <= idx3_reg;
        plo4_reg <= wmoc_pkg::PART_W'(sq3_reg[wmoc_pkg::SQ_LO_W-1:0])
                  * wmoc_pkg::PART_W'(cw3_reg);
        phi4_reg <= wmoc_pkg::PART_W'(sq3_reg[wmoc_pkg::SQ_W-1:wmoc_pkg::SQ_LO_W])
                  * wmoc_pkg::PART_W'(cw3_reg);
        idx5_reg <= idx4_reg;
        // saturate at the top of 64 bits
        dev5_reg <= (|dev_full[wmoc_pkg::FULL_W-1:wmoc_pkg::DEV_W]) ? '1
                  : dev_full[wmoc_pkg::DEV_W-1:0];
    end

    // running worst, strict compare keeps the earlier entry on a tie
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
            max_reg   <= '0;
            worst_reg <= '0;
        end
        else if (div_start)
        begin
            found_reg <= 1'b0;
            max_reg   <= '0;
            worst_reg <= '0;
        end
        else if (v5_reg && (dev5_reg > thr) && (dev5_reg > max_reg))
        begin
            found_reg <= 1'b1;
            max_reg   <= dev5_reg;
            worst_reg <= idx5_reg;
        end
    end

    // result fields
    assign res_clipped = group_ok && found_reg;
    assign res_worst   = res_clipped ? wmoc_pkg::INDEX_OUT_W'(worst_reg) : '0;
    assign res_count   = wmoc_pkg::COUNT_OUT_W'(head.fit_cnt - CNT_W'(res_clipped));
    assign res_mean    = group_ok ? mean_reg : '0;

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (finish)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            m_tdata_reg <= wmoc_pkg::OUT_TDATA_W'({res_mean, res_count, res_worst});
            m_tuser_reg <= {head.overflow, res_clipped};
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_tdata_reg;
    assign m_axis_tuser  = m_tuser_reg;

    // work on a group only while its descriptor is still queued
    `WMOC_ASSERT_IMPL(a_scan_has_group, clk, rst_n, state_reg == wmoc_pkg::BK_SCAN || state_reg == wmoc_pkg::BK_DIV, !q_status.empty, "back end busy without a group")
    // the last scan stage only runs inside the scan
    `WMOC_ASSERT_IMPL(a_stage_in_scan, clk, rst_n, v5_reg, state_reg == wmoc_pkg::BK_SCAN, "scan beat outside scan")
    // the mean is ready before the first read of the store
    `WMOC_ASSERT_NEXT(a_div_then_scan, clk, rst_n, div_done, state_reg == wmoc_pkg::BK_SCAN, "divide done without scan")

endmodule

// ===== sv/weighted_mean_outlier_clip.sv =====
// result: a group's last beat pushes its descriptor; the back end divides for the mean in
// 24 steps, reads the N stored detections one a cycle through the scan pipeline and
// registers the result beat; a group with fewer than two fittable detections skips both
// throughput: one detection beat per cycle while the queue has room, none in the cycle that
// pushes a descriptor; two store banks let the next group load while one is scanned
// reset: clears all control state and sets clip_sigma to 3.0; the store is not cleared
module weighted_mean_outlier_clip #(
    parameter int MAX_DETECTIONS = 64
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               clip_sigma_wr_en,
    input  logic [wmoc_pkg::SIGMA_W-1:0]       clip_sigma_wr_data,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // magnitude [23:0], weight [47:24], clip_weight [71:48]
    input  logic [wmoc_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // already_clipped
    input  logic                               s_axis_tuser,
    input  logic                               s_axis_tlast,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // worst_index [5:0], fit_count [12:6], weighted_mean [36:13], zero pad [39:37]
    output logic [wmoc_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    // clipped [0], overflow [1]
    output logic [wmoc_pkg::OUT_TUSER_W-1:0]   m_axis_tuser
);

    localparam int CNT_W  = $clog2(MAX_DETECTIONS + 1);
    localparam int IDX_W  = $clog2(MAX_DETECTIONS);
    localparam int SUMW_W = wmoc_pkg::WT_W + CNT_W;
    localparam int SUMM_W = wmoc_pkg::PROD_W + CNT_W;
    localparam int DESC_W = 2 + 2 * CNT_W + SUMW_W + SUMM_W;

    logic [wmoc_pkg::SIGMA_W-1:0]   clip_sigma_reg;
    wmoc_pkg::queue_status_t        q_status;
    logic                           q_push;
    logic                           q_pop;
    logic [DESC_W-1:0]              q_push_data;
    logic [DESC_W-1:0]              q_head_data;
    logic                           st_wr_en;
    logic [IDX_W:0]                 st_wr_addr;
    wmoc_pkg::store_word_t          st_wr_data;

    // clip threshold register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clip_sigma_reg <= wmoc_pkg::SIGMA_RESET;
        end
        else if (clip_sigma_wr_en)
        begin
            clip_sigma_reg <= clip_sigma_wr_data;
        end
    end

    // beat intake and group sums
    wmoc_front #(
        .MAX_DETECTIONS (MAX_DETECTIONS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .q_status      (q_status),
        .q_push        (q_push),
        .q_push_data   (q_push_data),
        .st_wr_en      (st_wr_en),
        .st_wr_addr    (st_wr_addr),
        .st_wr_data    (st_wr_data)
    );

    // group descriptors waiting for the back end
    wmoc_queue #(
        .WIDTH (DESC_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .pop       (q_pop),
        .head_data (q_head_data),
        .status    (q_status)
    );

    // mean, outlier scan and result beat
    wmoc_back #(
        .MAX_DETECTIONS (MAX_DETECTIONS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .st_wr_en      (st_wr_en),
        .st_wr_addr    (st_wr_addr),
        .st_wr_data    (st_wr_data),
        .head_data     (q_head_data),
        .q_status      (q_status),
        .q_pop         (q_pop),
        .clip_sigma    (clip_sigma_reg),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule
